FILE: hw/rtl/pqr_pkg.sv
// Shared opcodes, status codes, widths and the cell control bundle for the priority queue.
package pqr_pkg;

	localparam int PRIO_BITS  = 32;
	localparam int FIELD_BITS = 32;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_CHG = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic wr;
		logic del;
		logic chg;
		logic clr;
	} pqr_ctl_t;

endpackage

FILE: hw/rtl/pqr_cell.sv
// One storage cell of the queue with its stage of the head and free-slot scan.
module pqr_cell #(
	parameter int TAG_BITS = 32,
	parameter int IW       = 4,
	parameter int CW       = 5,
	parameter int IDX      = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pqr_pkg::pqr_ctl_t                    ctl,
	input  logic [IW-1:0]                        wr_idx,
	input  logic [IW-1:0]                        del_idx,
	input  logic [TAG_BITS-1:0]                  cmd_tag,
	input  logic signed [pqr_pkg::PRIO_BITS-1:0] cmd_prio,
	input  logic                                 live_in,
	input  logic                                 bv_in,
	input  logic [TAG_BITS-1:0]                  tag_in,
	input  logic signed [pqr_pkg::PRIO_BITS-1:0] prio_in,
	input  logic [IW-1:0]                        idx_in,
	input  logic                                 ff_in,
	input  logic [IW-1:0]                        fidx_in,
	input  logic [CW-1:0]                        cnt_in,
	output logic                                 live_q,
	output logic                                 bv_q,
	output logic [TAG_BITS-1:0]                  tag_q,
	output logic signed [pqr_pkg::PRIO_BITS-1:0] prio_q,
	output logic [IW-1:0]                        idx_q,
	output logic                                 ff_q,
	output logic [IW-1:0]                        fidx_q,
	output logic [CW-1:0]                        cnt_q
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic                                 v_q;
	logic [TAG_BITS-1:0]                  etag_q;
	logic signed [pqr_pkg::PRIO_BITS-1:0] eprio_q;
	logic                                 better;
	logic                                 take_free;

	always_comb begin
		better = v_q && (!bv_in || (eprio_q < prio_in) ||
			((eprio_q == prio_in) && (etag_q < tag_in)));
		take_free = !v_q && !ff_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= 1'b0;
			live_q <= 1'b0;
		end else begin
			live_q <= live_in;
			if (ctl.clr) begin
				v_q <= 1'b0;
			end else if (ctl.wr && (wr_idx == MY_IDX)) begin
				v_q <= 1'b1;
			end else if (ctl.del && (del_idx == MY_IDX)) begin
				v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && (wr_idx == MY_IDX)) begin
			etag_q  <= cmd_tag;
			eprio_q <= cmd_prio;
		end else if (ctl.chg && v_q && (etag_q == cmd_tag)) begin
			eprio_q <= cmd_prio;
		end
		// advance the scan token
		bv_q   <= bv_in | v_q;
		tag_q  <= better ? etag_q : tag_in;
		prio_q <= better ? eprio_q : prio_in;
		idx_q  <= better ? MY_IDX : idx_in;
		ff_q   <= ff_in | !v_q;
		fidx_q <= take_free ? MY_IDX : fidx_in;
		cnt_q  <= cnt_in + CW'(v_q);
	end

endmodule

FILE: hw/rtl/min_priority_queue_with_reprioritize_core.sv
// Top level of the bounded min-priority queue built as a chain of storage cells.
// Each request (enqueue, dequeue, change priority, clear) is applied to all cells in
// the cycle it is accepted; a scan token then walks the cell chain, one cell per
// cycle, to find the new head, the lowest free slot and the entry count. The result
// is registered once the token leaves the last cell of the chain; the next request
// is taken once the result is in the output register. Ties in priority go to the
// smaller tag; head fields read zero when the queue is empty.
module min_priority_queue_with_reprioritize_core #(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            opcode,
	input  logic [pqr_pkg::FIELD_BITS-1:0]        in_tag,
	input  logic signed [pqr_pkg::PRIO_BITS-1:0]  in_priority,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [pqr_pkg::FIELD_BITS-1:0]        out_tag,
	output logic [1:0]                            status,
	output logic [pqr_pkg::FIELD_BITS-1:0]        head_tag,
	output logic signed [pqr_pkg::PRIO_BITS-1:0]  head_priority,
	output logic [4:0]                            entry_count
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	state_t                               state_q;
	logic                                 start_q;
	logic                                 out_valid_q;
	logic [IW-1:0]                        hd_idx_q;
	logic [IW-1:0]                        fr_idx_q;
	logic [CW-1:0]                        cnt_q;
	logic [TAG_BITS-1:0]                  hd_tag_q;
	logic signed [pqr_pkg::PRIO_BITS-1:0] hd_prio_q;
	logic [1:0]                           stat_q;
	logic [TAG_BITS-1:0]                  deq_tag_q;
	logic [pqr_pkg::FIELD_BITS-1:0]       o_tag_q;
	logic [1:0]                           o_stat_q;
	logic [pqr_pkg::FIELD_BITS-1:0]       o_htag_q;
	logic signed [pqr_pkg::PRIO_BITS-1:0] o_hprio_q;
	logic [4:0]                           o_cnt_q;

	logic                                 accept;
	logic                                 is_full;
	logic                                 is_empty;
	logic [TAG_BITS-1:0]                  cmd_tag;
	pqr_pkg::pqr_ctl_t                    ctl;
	logic                                 out_load;

	logic                                 tk_live [CAPACITY+1];
	logic                                 tk_bv   [CAPACITY+1];
	logic [TAG_BITS-1:0]                  tk_tag  [CAPACITY+1];
	logic signed [pqr_pkg::PRIO_BITS-1:0] tk_prio [CAPACITY+1];
	logic [IW-1:0]                        tk_idx  [CAPACITY+1];
	logic                                 tk_ff   [CAPACITY+1];
	logic [IW-1:0]                        tk_fidx [CAPACITY+1];
	logic [CW-1:0]                        tk_cnt  [CAPACITY+1];

	assign in_ready      = (state_q == S_IDLE);
	assign accept        = in_valid && in_ready;
	assign is_full       = (cnt_q == CW'(CAPACITY));
	assign is_empty      = (cnt_q == '0);
	assign cmd_tag       = TAG_BITS'(in_tag);
	assign out_load      = (state_q == S_HOLD) && (!out_valid_q || out_ready);

	assign out_valid     = out_valid_q;
	assign out_tag       = o_tag_q;
	assign status        = o_stat_q;
	assign head_tag      = o_htag_q;
	assign head_priority = o_hprio_q;
	assign entry_count   = o_cnt_q;

	always_comb begin
		ctl = '0;
		if (accept) begin
			unique case (pqr_pkg::op_t'(opcode))
				pqr_pkg::OP_ENQ: ctl.wr  = !is_full;
				pqr_pkg::OP_DEQ: ctl.del = !is_empty;
				pqr_pkg::OP_CHG: ctl.chg = 1'b1;
				pqr_pkg::OP_CLR: ctl.clr = 1'b1;
			endcase
		end
	end

	// inject a fresh token at the head of the chain
	assign tk_live[0] = start_q;
	assign tk_bv[0]   = 1'b0;
	assign tk_tag[0]  = '0;
	assign tk_prio[0] = '0;
	assign tk_idx[0]  = '0;
	assign tk_ff[0]   = 1'b0;
	assign tk_fidx[0] = '0;
	assign tk_cnt[0]  = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		pqr_cell #(
			.TAG_BITS (TAG_BITS),
			.IW       (IW),
			.CW       (CW),
			.IDX      (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_idx   (fr_idx_q),
			.del_idx  (hd_idx_q),
			.cmd_tag  (cmd_tag),
			.cmd_prio (in_priority),
			.live_in  (tk_live[g]),
			.bv_in    (tk_bv[g]),
			.tag_in   (tk_tag[g]),
			.prio_in  (tk_prio[g]),
			.idx_in   (tk_idx[g]),
			.ff_in    (tk_ff[g]),
			.fidx_in  (tk_fidx[g]),
			.cnt_in   (tk_cnt[g]),
			.live_q   (tk_live[g+1]),
			.bv_q     (tk_bv[g+1]),
			.tag_q    (tk_tag[g+1]),
			.prio_q   (tk_prio[g+1]),
			.idx_q    (tk_idx[g+1]),
			.ff_q     (tk_ff[g+1]),
			.fidx_q   (tk_fidx[g+1]),
			.cnt_q    (tk_cnt[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			hd_idx_q    <= '0;
			fr_idx_q    <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						start_q <= 1'b1;
					end
				end
				S_SCAN: begin
					start_q <= 1'b0;
					if (tk_live[CAPACITY]) begin
						hd_idx_q <= tk_idx[CAPACITY];
						fr_idx_q <= tk_fidx[CAPACITY];
						cnt_q    <= tk_cnt[CAPACITY];
						state_q  <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deq_tag_q <= ctl.del ? hd_tag_q : '0;
			priority case (1'b1)
				(pqr_pkg::op_t'(opcode) == pqr_pkg::OP_ENQ) && is_full:
					stat_q <= pqr_pkg::ST_FULL;
				(pqr_pkg::op_t'(opcode) == pqr_pkg::OP_DEQ) && is_empty:
					stat_q <= pqr_pkg::ST_EMPTY;
				default:
					stat_q <= pqr_pkg::ST_OK;
			endcase
		end
		if ((state_q == S_SCAN) && tk_live[CAPACITY]) begin
			hd_tag_q  <= tk_bv[CAPACITY] ? tk_tag[CAPACITY] : '0;
			hd_prio_q <= tk_bv[CAPACITY] ? tk_prio[CAPACITY] : '0;
		end
		if (out_load) begin
			o_tag_q   <= pqr_pkg::FIELD_BITS'(deq_tag_q);
			o_stat_q  <= stat_q;
			o_htag_q  <= pqr_pkg::FIELD_BITS'(hd_tag_q);
			o_hprio_q <= hd_prio_q;
			o_cnt_q   <= 5'(cnt_q);
		end
	end

endmodule

FILE: hw/rtl/pqr_checker.sv
// Port-level checks for the priority queue core and their binding to it.
module pqr_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [pqr_pkg::FIELD_BITS-1:0]        out_tag,
	input logic [1:0]                            status,
	input logic [pqr_pkg::FIELD_BITS-1:0]        head_tag,
	input logic signed [pqr_pkg::PRIO_BITS-1:0]  head_priority,
	input logic [4:0]                            entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(status)
			&& $stable(head_tag) && $stable(entry_count))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_count == '0) |-> (head_tag == '0) && (head_priority == '0))
		else $error("empty queue reports a head");

	a_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == pqr_pkg::ST_EMPTY) |-> (out_tag == '0) && (entry_count == '0))
		else $error("dequeue on empty queue reports data");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == pqr_pkg::ST_FULL) |-> (out_tag == '0) && (entry_count != '0))
		else $error("dropped enqueue reports data");

endmodule

bind min_priority_queue_with_reprioritize_core pqr_checker u_pqr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_tag       (out_tag),
	.status        (status),
	.head_tag      (head_tag),
	.head_priority (head_priority),
	.entry_count   (entry_count)
);

FILE: sim/tb_min_priority_queue_with_reprioritize_core.sv
// Self-checking testbench for the min-priority queue core: directed table, then random requests.
`timescale 1ns / 1ps

module tb_min_priority_queue_with_reprioritize_core;

	localparam int CAPACITY     = 16;
	localparam int TAG_BITS     = 32;
	localparam int LATENCY      = CAPACITY + 2;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 240;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AT      = 600;
	localparam int N_DIRECTED   = 14;

	typedef struct packed {
		logic [31:0]        tag;
		pqr_pkg::status_t   st;
		logic [31:0]        htag;
		logic signed [31:0] hprio;
		logic [4:0]         cnt;
	} pq_result_t;

	typedef struct packed {
		pqr_pkg::op_t       op;
		logic [31:0]        tag;
		logic signed [31:0] prio;
		int                 reps;
		bit                 typed;
		pq_result_t         want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          opcode;
	logic [31:0]         in_tag;
	logic signed [31:0]  in_priority;
	logic                out_valid;
	logic                out_ready;
	logic [31:0]         out_tag;
	logic [1:0]          status;
	logic [31:0]         head_tag;
	logic signed [31:0]  head_priority;
	logic [4:0]          entry_count;

	logic [31:0]         slot_tag  [CAPACITY];
	logic signed [31:0]  slot_prio [CAPACITY];
	bit                  slot_used [CAPACITY];

	pq_result_t          pending_results [$];
	int                  mismatches;
	int                  results_seen;
	int                  cycle_count;
	int                  op_counts [4];
	int                  full_drops;
	int                  empty_dequeues;
	int                  peak_depth;
	bit                  no_idle;

	dir_row_t directed_rows [N_DIRECTED] = '{
		'{pqr_pkg::OP_DEQ, 32'h0, 32'sh0, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_EMPTY, 32'h0, 32'sh0, 5'd0}},
		'{pqr_pkg::OP_CLR, 32'h0, 32'sh0, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'h0, 32'sh0, 5'd0}},
		'{pqr_pkg::OP_CHG, 32'h5, 32'sh1, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'h0, 32'sh0, 5'd0}},
		'{pqr_pkg::OP_ENQ, 32'hFFFFFFFF, 32'sh7FFFFFFF, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'hFFFFFFFF, 32'sh7FFFFFFF, 5'd1}},
		'{pqr_pkg::OP_ENQ, 32'h0, 32'sh80000000, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'h0, 32'sh80000000, 5'd2}},
		'{pqr_pkg::OP_ENQ, 32'hA, 32'sh80000000, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'h0, 32'sh80000000, 5'd3}},
		'{pqr_pkg::OP_CHG, 32'h0, 32'sh7FFFFFFF, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'hA, 32'sh80000000, 5'd3}},
		'{pqr_pkg::OP_CHG, 32'h1234, 32'sh0, 1, 1'b0, '0},
		'{pqr_pkg::OP_DEQ, 32'h0, 32'sh0, 1, 1'b0, '0},
		'{pqr_pkg::OP_ENQ, 32'h7, -32'sd1, 14, 1'b0, '0},
		'{pqr_pkg::OP_ENQ, 32'h99, -32'sd5, 1, 1'b0, '0},
		'{pqr_pkg::OP_CHG, 32'h7, 32'sd5, 1, 1'b0, '0},
		'{pqr_pkg::OP_DEQ, 32'h0, 32'sh0, 1, 1'b0, '0},
		'{pqr_pkg::OP_CLR, 32'h0, 32'sh0, 1, 1'b1,
			'{32'h0, pqr_pkg::ST_OK, 32'h0, 32'sh0, 5'd0}}
	};

	min_priority_queue_with_reprioritize_core #(
		.CAPACITY(CAPACITY),
		.TAG_BITS(TAG_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.in_tag(in_tag),
		.in_priority(in_priority),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_tag(out_tag),
		.status(status),
		.head_tag(head_tag),
		.head_priority(head_priority),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int head_slot();
		int best;
		best = -1;
		for (int i = 0; i < CAPACITY; i++) begin
			if (slot_used[i] && (best < 0 || slot_prio[i] < slot_prio[best] ||
					(slot_prio[i] == slot_prio[best] && slot_tag[i] < slot_tag[best])))
				best = i;
		end
		return best;
	endfunction

	task automatic predict_queue_result(input pqr_pkg::op_t op, input logic [31:0] tag,
			input logic signed [31:0] prio, output pq_result_t r);
		int free_slot;
		int h;
		int cnt;
		r = '0;
		r.st = pqr_pkg::ST_OK;
		free_slot = -1;
		cnt = 0;
		case (op)
			pqr_pkg::OP_ENQ: begin
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!slot_used[i])
						free_slot = i;
				if (free_slot < 0) begin
					r.st = pqr_pkg::ST_FULL;
				end else begin
					slot_tag[free_slot]  = tag;
					slot_prio[free_slot] = prio;
					slot_used[free_slot] = 1'b1;
				end
			end
			pqr_pkg::OP_DEQ: begin
				h = head_slot();
				if (h < 0) begin
					r.st = pqr_pkg::ST_EMPTY;
				end else begin
					r.tag = slot_tag[h];
					slot_used[h] = 1'b0;
				end
			end
			pqr_pkg::OP_CHG: begin
				for (int i = 0; i < CAPACITY; i++)
					if (slot_used[i] && slot_tag[i] == tag)
						slot_prio[i] = prio;
			end
			default: begin
				for (int i = 0; i < CAPACITY; i++)
					slot_used[i] = 1'b0;
			end
		endcase
		for (int i = 0; i < CAPACITY; i++)
			if (slot_used[i])
				cnt++;
		h = head_slot();
		if (h >= 0) begin
			r.htag  = slot_tag[h];
			r.hprio = slot_prio[h];
		end
		r.cnt = cnt[4:0];
	endtask

	task automatic send_request(input pqr_pkg::op_t op, input logic [31:0] tag,
			input logic signed [31:0] prio, input bit typed, input pq_result_t want);
		int gap;
		pq_result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		in_tag      <= tag;
		in_priority <= prio;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_queue_result(op, tag, prio, predicted);
		op_counts[op]++;
		if (predicted.st == pqr_pkg::ST_FULL)
			full_drops++;
		if (predicted.st == pqr_pkg::ST_EMPTY)
			empty_dequeues++;
		if (predicted.cnt > peak_depth)
			peak_depth = predicted.cnt;
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: result %0d %s expected %h actual %h", $time, results_seen,
				name, want, got);
		end
	endtask

	// result side: random stalls, one long hold-off
	initial begin
		int stall;
		pq_result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == HOLD_AT)
				stall = LONG_HOLD;
			else
				stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result expected none actual tag %h status %h count %0d",
					$time, out_tag, status, entry_count);
			end else begin
				want = pending_results.pop_front();
				compare_field("out_tag", want.tag, out_tag);
				compare_field("status", 32'(want.st), 32'(status));
				compare_field("head_tag", want.htag, head_tag);
				compare_field("head_priority", want.hprio, head_priority);
				compare_field("entry_count", 32'(want.cnt), 32'(entry_count));
			end
			results_seen++;
		end
	end

	// request side
	initial begin
		pqr_pkg::op_t       op;
		logic [31:0]        tag;
		logic signed [31:0] prio;
		logic [31:0]        stored [$];
		int                 enq_pct;
		int                 deq_pct;
		int                 chg_pct;
		int                 pick;
		bit                 narrow;

		mismatches     = 0;
		results_seen   = 0;
		cycle_count    = 0;
		full_drops     = 0;
		empty_dequeues = 0;
		peak_depth     = 0;
		no_idle        = 1'b0;
		for (int i = 0; i < 4; i++)
			op_counts[i] = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_tag[i]  = '0;
			slot_prio[i] = '0;
			slot_used[i] = 1'b0;
		end

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		opcode      <= pqr_pkg::OP_ENQ;
		in_tag      <= '0;
		in_priority <= '0;
		out_ready   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++)
			for (int k = 0; k < directed_rows[r].reps; k++)
				send_request(directed_rows[r].op, directed_rows[r].tag, directed_rows[r].prio,
					directed_rows[r].typed, directed_rows[r].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase == 3 || phase == 6);
			narrow  = (phase % 2 == 0);
			if (phase == 4) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (pending_results.size() != 0);
			end
			case (phase % 4)
				0:       begin enq_pct = 62; deq_pct = 20; chg_pct = 16; end
				1:       begin enq_pct = 30; deq_pct = 54; chg_pct = 14; end
				2:       begin enq_pct = 45; deq_pct = 38; chg_pct = 15; end
				default: begin enq_pct = 55; deq_pct = 30; chg_pct = 13; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < enq_pct)
					op = pqr_pkg::OP_ENQ;
				else if (pick < enq_pct + deq_pct)
					op = pqr_pkg::OP_DEQ;
				else if (pick < enq_pct + deq_pct + chg_pct)
					op = pqr_pkg::OP_CHG;
				else
					op = pqr_pkg::OP_CLR;

				if (narrow) begin
					case ($urandom_range(0, 5))
						0:       tag = 32'h0;
						1:       tag = 32'h1;
						2:       tag = 32'h2;
						3:       tag = 32'h80000000;
						4:       tag = 32'hFFFFFFFF;
						default: tag = 32'h3;
					endcase
				end else begin
					tag = $urandom;
				end

				// retarget most priority changes at a stored tag
				if (op == pqr_pkg::OP_CHG && $urandom_range(0, 3) != 0) begin
					stored.delete();
					for (int s = 0; s < CAPACITY; s++)
						if (slot_used[s])
							stored.push_back(slot_tag[s]);
					if (stored.size() != 0)
						tag = stored[$urandom_range(0, stored.size() - 1)];
				end

				case ($urandom_range(0, 9))
					0:       prio = 32'sh80000000;
					1:       prio = 32'sh7FFFFFFF;
					2, 3, 4, 5: prio = $signed(32'($urandom_range(0, 6))) - 32'sd3;
					default: prio = $urandom;
				endcase

				send_request(op, tag, prio, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		no_idle  = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("covered %0d requests: %0d enqueue, %0d dequeue, %0d change, %0d clear",
			op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3],
			op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
		$display("drops on full %0d, dequeues on empty %0d, peak depth %0d, mismatches %0d",
			full_drops, empty_dequeues, peak_depth, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
